// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL of the positional list store.
// Include by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a plain property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pls_pkg.sv =====
// Shared types and constants of the positional list store.
// Used by pls_cell and positional_list_store; depends on nothing.
package pls_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int MAX_DEPTH     = 64;
    // wide enough for any count up to MAX_DEPTH
    localparam int CNT_W         = $clog2(MAX_DEPTH + 1);
    localparam int VAL_W         = 32;
    localparam int MODE_W        = 3;
    localparam int POS_W         = 6;
    localparam int STATUS_W      = 2;
    localparam int IDX_W         = 6;
    localparam int LEN_W         = 6;
    localparam int S_DATA_W      = 48;
    localparam int M_DATA_W      = 48;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR  = 3'd0,
        MODE_APPEND = 3'd1,
        MODE_INSERT = 3'd2,
        MODE_DELETE = 3'd3,
        MODE_READ   = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_RANGE = 2'd2,
        STATUS_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_ROTATE = 2'd3
    } cell_op_t;

    // Broadcast to every cell of the chain in each cycle.
    typedef struct packed {
        cell_op_t                 op;
        logic [CNT_W-1:0]         pos;   // insert or delete position
        logic [CNT_W-1:0]         tail;  // index of the last stored element
        logic signed [VAL_W-1:0]  value; // value to load at pos
        logic signed [VAL_W-1:0]  head;  // value of cell 0, wraps to tail on rotate
    } cell_ctrl_t;

endpackage

// ===== hdl/pls_cell.sv =====
// One storage cell of the positional list store chain.
// Depends on pls_pkg for the broadcast control struct.
module pls_cell #(
    parameter int INDEX = 0
) (
    input  logic                                aclk,
    input  pls_pkg::cell_ctrl_t                 ctrl_i,
    input  logic signed [pls_pkg::VAL_W-1:0]    left_i,
    input  logic signed [pls_pkg::VAL_W-1:0]    right_i,
    output logic signed [pls_pkg::VAL_W-1:0]    value_o
);

    localparam int CW = pls_pkg::CNT_W;
    localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

    logic signed [pls_pkg::VAL_W-1:0] value_reg;
    logic signed [pls_pkg::VAL_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        unique case (ctrl_i.op)
            pls_pkg::OP_INSERT: begin
                // open a slot at pos, shift everything behind it one place back
                if (MY_IDX == ctrl_i.pos) begin
                    value_next = ctrl_i.value;
                end else if (MY_IDX > ctrl_i.pos) begin
                    value_next = left_i;
                end
            end
            pls_pkg::OP_DELETE: begin
                if (MY_IDX >= ctrl_i.pos) begin
                    value_next = right_i;
                end
            end
            pls_pkg::OP_ROTATE: begin
                // advance toward the head; the head wraps to the tail
                if (MY_IDX == ctrl_i.tail) begin
                    value_next = ctrl_i.head;
                end else if (MY_IDX < ctrl_i.tail) begin
                    value_next = right_i;
                end
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value_o = value_reg;

endmodule

// ===== hdl/positional_list_store.sv =====
// Top level of the positional list store: input holding stage, control, cell chain,
// output register. Depends on pls_pkg, pls_cell and assert_macros.svh.
//
// Ordered list of up to DEPTH signed 32-bit values held in a row of cells that all
// shift in the same cycle. Each input transfer clears the list, appends at the tail,
// inserts at a position, deletes at a position, or reads the whole list out. Clear,
// append, insert, delete and unused mode codes give one result transfer carrying the
// status and the length after the operation. A read of a list of N elements gives N
// result transfers, head first, with tlast on the final one; the chain rotates by one
// cell per cycle while results are taken, and cell 0 is the read port, so once the last
// element is out the list is back in place. A read of an empty list gives one result
// with status empty. The input is held in a one-deep stage, so the next transfer is
// taken while the current result waits downstream; while the receiver keeps up, the
// sustained rate is one item per cycle for non-read items, and a read holds the input
// stage until its final element is out. There is no clearing pass after reset: the
// length resets to zero and cells beyond the length are never read. Status codes: 0 ok,
// 1 empty, 2 position out of range, 3 full. Insert into an empty list is refused with
// status empty; insert at a position equal to the length appends.
module positional_list_store #(
    parameter int DEPTH = pls_pkg::DEPTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: mode[2:0], position[8:3], value[40:9], zero[47:41]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pls_pkg::S_DATA_W-1:0]    s_tdata,
    // m_tdata: status[1:0], element[33:2], element_index[39:34], length[45:40], zero[47:46]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pls_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                            m_tlast
);

`include "assert_macros.svh"

    localparam int CW  = pls_pkg::CNT_W;
    localparam int LW  = $clog2(DEPTH + 1);   // list length
    localparam int IW  = $clog2(DEPTH);       // read index
    localparam int VW  = pls_pkg::VAL_W;
    localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

    // ---------------- input holding stage ----------------
    logic                             item_valid_reg;
    logic [pls_pkg::MODE_W-1:0]       item_mode_reg;
    logic [pls_pkg::POS_W-1:0]        item_pos_reg;
    logic signed [VW-1:0]             item_value_reg;

    // ---------------- list control ----------------
    logic [LW-1:0]                    count_reg;
    logic [LW-1:0]                    count_next;
    logic [IW-1:0]                    rd_idx_reg;
    logic [IW-1:0]                    rd_idx_next;

    // ---------------- output register ----------------
    logic                             out_valid_reg;
    logic [pls_pkg::M_DATA_W-1:0]     out_data_reg;
    logic                             out_last_reg;

    logic                             out_free;
    logic                             work;       // the held item advances this cycle
    logic                             item_done;  // the held item gave its final result
    logic                             in_take;

    pls_pkg::cell_ctrl_t              ctrl;
    pls_pkg::status_t                 res_status;
    logic signed [VW-1:0]             res_element;
    logic [pls_pkg::IDX_W-1:0]        res_index;
    logic                             res_last;
    logic [CW-1:0]                    count_w;
    logic [CW-1:0]                    pos_w;

    logic signed [VW-1:0]             cell_value [DEPTH];

    assign out_free  = !out_valid_reg || m_tready;
    assign work      = item_valid_reg && out_free;
    assign s_tready  = !item_valid_reg || item_done;
    assign in_take   = s_tvalid && s_tready;

    assign count_w   = CW'(count_reg);
    assign pos_w     = CW'(item_pos_reg);

    // Decode the held item into a chain command, the next length and a result.
    always_comb begin
        ctrl.op     = pls_pkg::OP_HOLD;
        ctrl.pos    = pos_w;
        ctrl.tail   = count_w - CW'(1);
        ctrl.value  = item_value_reg;
        ctrl.head   = cell_value[0];
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        res_status  = pls_pkg::STATUS_OK;
        res_element = '0;
        res_index   = '0;
        res_last    = 1'b1;
        item_done   = work;

        unique case (item_mode_reg)
            pls_pkg::MODE_CLEAR: begin
                count_next = '0;
            end
            pls_pkg::MODE_APPEND: begin
                if (count_reg >= DEPTH_L) begin
                    res_status = pls_pkg::STATUS_FULL;
                end else begin
                    ctrl.op    = pls_pkg::OP_INSERT;
                    ctrl.pos   = count_w;
                    count_next = count_reg + LW'(1);
                end
            end
            pls_pkg::MODE_INSERT: begin
                // empty and range take precedence over full
                if (count_reg == '0) begin
                    res_status = pls_pkg::STATUS_EMPTY;
                end else if (pos_w > count_w) begin
                    res_status = pls_pkg::STATUS_RANGE;
                end else if (count_reg >= DEPTH_L) begin
                    res_status = pls_pkg::STATUS_FULL;
                end else begin
                    ctrl.op    = pls_pkg::OP_INSERT;
                    count_next = count_reg + LW'(1);
                end
            end
            pls_pkg::MODE_DELETE: begin
                if (count_reg == '0) begin
                    res_status = pls_pkg::STATUS_EMPTY;
                end else if (pos_w >= count_w) begin
                    res_status = pls_pkg::STATUS_RANGE;
                end else begin
                    ctrl.op    = pls_pkg::OP_DELETE;
                    count_next = count_reg - LW'(1);
                end
            end
            pls_pkg::MODE_READ: begin
                if (count_reg == '0) begin
                    res_status = pls_pkg::STATUS_EMPTY;
                end else begin
                    // stream the head, rotate the chain, hold the item until the tail
                    ctrl.op     = pls_pkg::OP_ROTATE;
                    res_element = cell_value[0];
                    res_index   = pls_pkg::IDX_W'(rd_idx_reg);
                    res_last    = (CW'(rd_idx_reg) == count_w - CW'(1));
                    item_done   = work && res_last;
                    rd_idx_next = res_last ? '0 : rd_idx_reg + IW'(1);
                end
            end
            default: begin
                // unused mode codes: report ok, change nothing
                res_status = pls_pkg::STATUS_OK;
            end
        endcase

        if (!work) begin
            ctrl.op     = pls_pkg::OP_HOLD;
            count_next  = count_reg;
            rd_idx_next = rd_idx_reg;
        end
    end

    // ---------------- cell chain ----------------
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [VW-1:0] left_w;
        logic signed [VW-1:0] right_w;

        if (i == 0) begin : g_head
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = cell_value[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = cell_value[i+1];
        end

        pls_cell #(
            .INDEX (i)
        ) u_cell (
            .aclk    (aclk),
            .ctrl_i  (ctrl),
            .left_i  (left_w),
            .right_i (right_w),
            .value_o (cell_value[i])
        );
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
            if (in_take) begin
                item_valid_reg <= 1'b1;
            end else if (item_done) begin
                item_valid_reg <= 1'b0;
            end
            if (work) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: hold the item and the result, no reset needed.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            item_mode_reg  <= s_tdata[2:0];
            item_pos_reg   <= s_tdata[8:3];
            item_value_reg <= s_tdata[40:9];
        end
        if (work) begin
            out_data_reg <= {2'b00,
                             pls_pkg::LEN_W'(count_next),
                             res_index,
                             res_element,
                             res_status};
            out_last_reg <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // ---------------- assertions ----------------
    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= DEPTH_L,
        "list length exceeds DEPTH")
    `ASSERT_IMPLIES(a_rd_idx_owner, aclk, aresetn, rd_idx_reg != '0,
        item_valid_reg && item_mode_reg == pls_pkg::MODE_READ,
        "read index advanced without a read in progress")
    `ASSERT_IMPLIES(a_rd_idx_range, aclk, aresetn, rd_idx_reg != '0,
        LW'(rd_idx_reg) < count_reg, "read index beyond list length")
    `ASSERT_NEXT(a_work_out, aclk, aresetn, work, out_valid_reg,
        "advanced item produced no result")
    `ASSERT_IMPLIES(a_no_drop, aclk, aresetn, out_valid_reg && !m_tready, !work,
        "held item advanced while the result register was blocked")

endmodule

// ===== sim/positional_list_store_tb.sv =====
// Self-checking testbench for positional_list_store: stream stimulus, bursty sender,
// patterned receiver stalls, and a scoreboard class that predicts every result transfer.
// Depends on pls_pkg and the positional_list_store RTL only.
module positional_list_store_tb;

    localparam int VAL_W    = pls_pkg::VAL_W;
    localparam int MODE_W   = pls_pkg::MODE_W;
    localparam int POS_W    = pls_pkg::POS_W;
    localparam int IDX_W    = pls_pkg::IDX_W;
    localparam int LEN_W    = pls_pkg::LEN_W;
    localparam int S_DATA_W = pls_pkg::S_DATA_W;
    localparam int M_DATA_W = pls_pkg::M_DATA_W;

    localparam int LIST_DEPTH    = pls_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS  = 70;
    localparam int STALL_LIMIT   = 2000;  // cycles without any transfer before giving up
    localparam int DRAIN_CYCLES  = 16;    // settle time after the last expected result
    localparam int REPORT_LIMIT  = 10;

    // Mode codes the block does not define; it answers them with a plain ok.
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_MID   = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_EVERY_K,
        RX_LONG_STALL
    } rx_pattern_t;

    typedef struct packed {
        pls_pkg::status_t        status;
        logic signed [VAL_W-1:0] element;
        logic [IDX_W-1:0]        elem_index;
        logic [LEN_W-1:0]        length;
        logic                    last;
    } list_result_t;

    // Shadow copy of the list plus the queue of result transfers still owed by the block.
    class list_scoreboard;
        logic signed [VAL_W-1:0] cells [LIST_DEPTH];
        int unsigned             stored;
        list_result_t            pending_results [$];
        int                      mismatches;
        int                      inputs_seen;
        int                      results_seen;
        int                      status_tally [4];

        function new();
            stored       = 0;
            mismatches   = 0;
            inputs_seen  = 0;
            results_seen = 0;
            foreach (status_tally[i]) status_tally[i] = 0;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function void queue_result(pls_pkg::status_t st, logic signed [VAL_W-1:0] elem,
                                   int unsigned idx, logic fin);
            list_result_t r;
            r.status     = st;
            r.element    = elem;
            r.elem_index = idx[IDX_W-1:0];
            r.length     = stored[LEN_W-1:0];
            r.last       = fin;
            pending_results.push_back(r);
            status_tally[st]++;
        endfunction

        // Apply one accepted input transfer to the shadow list and queue its results.
        function void note_input(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                                 logic signed [VAL_W-1:0] val);
            pls_pkg::status_t st;
            int unsigned      p;
            st = pls_pkg::STATUS_OK;
            p  = 32'(pos);
            inputs_seen++;
            case (mode)
                pls_pkg::MODE_CLEAR: begin
                    stored = 0;
                end
                pls_pkg::MODE_APPEND: begin
                    if (stored >= LIST_DEPTH) begin
                        st = pls_pkg::STATUS_FULL;
                    end else begin
                        cells[stored] = val;
                        stored++;
                    end
                end
                pls_pkg::MODE_INSERT: begin
                    // empty and range take precedence over full
                    if (stored == 0) begin
                        st = pls_pkg::STATUS_EMPTY;
                    end else if (p > stored) begin
                        st = pls_pkg::STATUS_RANGE;
                    end else if (stored >= LIST_DEPTH) begin
                        st = pls_pkg::STATUS_FULL;
                    end else begin
                        for (int i = stored; i > p; i--) cells[i] = cells[i-1];
                        cells[p] = val;
                        stored++;
                    end
                end
                pls_pkg::MODE_DELETE: begin
                    if (stored == 0) begin
                        st = pls_pkg::STATUS_EMPTY;
                    end else if (p >= stored) begin
                        st = pls_pkg::STATUS_RANGE;
                    end else begin
                        for (int i = p; i + 1 < stored; i++) cells[i] = cells[i+1];
                        stored--;
                    end
                end
                pls_pkg::MODE_READ: begin
                    if (stored == 0) begin
                        queue_result(pls_pkg::STATUS_EMPTY, '0, 0, 1'b1);
                    end else begin
                        for (int i = 0; i < stored; i++)
                            queue_result(pls_pkg::STATUS_OK, cells[i], i, (i + 1 == stored));
                    end
                    return;
                end
                default: begin
                end
            endcase
            queue_result(st, '0, 0, 1'b1);
        endfunction

        // Compare one accepted result transfer with the oldest expectation.
        function void check_result(logic [M_DATA_W-1:0] data, logic fin);
            list_result_t got;
            list_result_t want;
            got.status     = pls_pkg::status_t'(data[1:0]);
            got.element    = data[33:2];
            got.elem_index = data[39:34];
            got.length     = data[45:40];
            got.last       = fin;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"unexpected result: status %0d element %0d index %0d",
                              " len %0d last %0b"},
                             got.status, got.element, got.elem_index, got.length, got.last);
                return;
            end
            want = pending_results.pop_front();
            if (got.status != want.status || got.element != want.element ||
                got.elem_index != want.elem_index || got.length != want.length ||
                got.last != want.last) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("result %0d mismatch", results_seen);
                    $display("  expected: status %0d element %0d index %0d len %0d last %0b",
                             want.status, want.element, want.elem_index, want.length,
                             want.last);
                    $display("  actual:   status %0d element %0d index %0d len %0d last %0b",
                             got.status, got.element, got.elem_index, got.length, got.last);
                end
            end
        endfunction
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;

    list_scoreboard sb = new();
    int             burst_left = 0;

    always #2 aclk = ~aclk;

    positional_list_store #(
        .DEPTH(LIST_DEPTH)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Present one item at the falling edge, hold it until the transfer, then note it.
    // The sender runs in bursts; at the end of a burst drop tvalid for a random gap, which may be zero.
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                             input logic signed [VAL_W-1:0] val);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - MODE_W - POS_W - VAL_W){1'b0}}, val, pos, mode};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(mode, pos, val);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    // Grow the list to full with appends and in-range inserts, push against the limit, then read it out.
    task automatic fill_list();
        while (sb.stored < LIST_DEPTH) begin
            if (sb.stored > 0 && $urandom_range(0, 3) == 0)
                send_item(pls_pkg::MODE_INSERT, POS_W'($urandom_range(0, sb.stored)),
                          $urandom);
            else
                send_item(pls_pkg::MODE_APPEND, POS_W'($urandom), $urandom);
        end
        send_item(pls_pkg::MODE_APPEND, POS_W'($urandom), $urandom);
        send_item(pls_pkg::MODE_INSERT, POS_W'($urandom_range(0, sb.stored)), $urandom);
        send_item(pls_pkg::MODE_INSERT, POS_W'($urandom_range(sb.stored + 1, 63)),
                  $urandom);
        send_item(pls_pkg::MODE_READ, POS_W'($urandom), $urandom);
    endtask

    // Delete from random valid positions until empty, then hit the empty cases.
    task automatic drain_list();
        while (sb.stored > 0)
            send_item(pls_pkg::MODE_DELETE, POS_W'($urandom_range(0, sb.stored - 1)),
                      $urandom);
        send_item(pls_pkg::MODE_DELETE, POS_W'($urandom), $urandom);
        send_item(pls_pkg::MODE_INSERT, POS_W'($urandom), $urandom);
        send_item(pls_pkg::MODE_READ, POS_W'($urandom), $urandom);
    endtask

    // One item of mixed traffic; positions mostly valid for the current length.
    task automatic random_item();
        int                  pick;
        logic [POS_W-1:0]    pos;
        logic [MODE_W-1:0]   mode;
        pick = $urandom_range(0, 99);
        pos  = POS_W'($urandom);
        if (pick < 4) begin
            mode = pls_pkg::MODE_CLEAR;
        end else if (pick < 34) begin
            mode = pls_pkg::MODE_APPEND;
        end else if (pick < 54) begin
            mode = pls_pkg::MODE_INSERT;
            if ($urandom_range(0, 4) != 0) pos = POS_W'($urandom_range(0, sb.stored));
        end else if (pick < 76) begin
            mode = pls_pkg::MODE_DELETE;
            if (sb.stored > 0 && $urandom_range(0, 4) != 0)
                pos = POS_W'($urandom_range(0, sb.stored - 1));
        end else if (pick < 88) begin
            mode = pls_pkg::MODE_READ;
        end else if (pick < 93) begin
            mode = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        end else begin
            mode = MODE_W'($urandom);  // noise: any code, any position
        end
        send_item(mode, pos, $urandom);
    endtask

    // Count every result transfer into the scoreboard at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
    end

    // Receiver: switch among stall patterns, each held for a random span of cycles.
    initial begin
        rx_pattern_t pattern;
        int          span;
        int          k;
        wait (aresetn);
        forever begin
            pattern = rx_pattern_t'($urandom_range(RX_OPEN, RX_LONG_STALL));
            span    = $urandom_range(16, 64);
            k       = $urandom_range(2, 5);
            for (int c = 0; c < span; c++) begin
                @(negedge aclk);
                case (pattern)
                    RX_OPEN:     m_tready <= 1'b1;
                    RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
                    RX_EVERY_K:  m_tready <= (c % k == 0);
                    default:     m_tready <= (c % 10 >= 8);  // long stall, short window
                endcase
            end
        end
    end

    // Watchdog: end the run once nothing has moved on either side for too long.
    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int directed_items;

        // Hold reset, then release it away from the sampling edge.
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty-list refusals first.
        send_item(pls_pkg::MODE_READ,   6'd0,  32'sd0);
        send_item(pls_pkg::MODE_INSERT, 6'd0,  32'sd7);
        send_item(pls_pkg::MODE_DELETE, 6'd0,  32'sd0);
        // Append to empty, then delete the only element and check the list reads empty.
        send_item(pls_pkg::MODE_APPEND, 6'd0,  VAL_MIN);
        send_item(pls_pkg::MODE_DELETE, 6'd0,  32'sd0);
        send_item(pls_pkg::MODE_READ,   6'd0,  32'sd0);
        // Build a short list with the value extremes and both insert ends.
        send_item(pls_pkg::MODE_APPEND, 6'd63, VAL_MAX);
        send_item(pls_pkg::MODE_APPEND, 6'd0,  -32'sd1);
        send_item(pls_pkg::MODE_INSERT, 6'd0,  32'sd0);
        send_item(pls_pkg::MODE_INSERT, 6'd3,  32'sd12345);   // position equal to length
        send_item(pls_pkg::MODE_INSERT, 6'd5,  VAL_MIN);      // beyond the length
        send_item(pls_pkg::MODE_INSERT, 6'd63, VAL_MAX);
        send_item(pls_pkg::MODE_DELETE, 6'd4,  32'sd0);       // position equal to length
        send_item(pls_pkg::MODE_DELETE, 6'd63, 32'sd0);
        send_item(pls_pkg::MODE_READ,   6'd0,  32'sd0);
        send_item(pls_pkg::MODE_DELETE, 6'd3,  32'sd0);       // tail
        send_item(pls_pkg::MODE_DELETE, 6'd1,  32'sd0);       // middle
        // Unused codes must leave the list alone.
        send_item(MODE_SPARE_FIRST, POS_W'($urandom), $urandom);
        send_item(MODE_SPARE_MID,   POS_W'($urandom), $urandom);
        send_item(MODE_SPARE_LAST,  POS_W'($urandom), $urandom);
        send_item(pls_pkg::MODE_READ,   6'd0,  32'sd0);
        send_item(pls_pkg::MODE_CLEAR,  6'd63, VAL_MAX);
        send_item(pls_pkg::MODE_READ,   6'd0,  32'sd0);
        directed_items = sb.inputs_seen;

        // Random: reach full at least once, then mix traffic with fill and drain runs.
        fill_list();
        while (sb.inputs_seen < directed_items + RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1:    fill_list();
                2, 3:    drain_list();
                default: repeat ($urandom_range(8, 20)) random_item();
            endcase
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Wait for every owed result, then give the block time to show any stray one.
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d input transfers and %0d result transfers",
                 sb.inputs_seen, sb.results_seen);
        $display("statuses seen: ok %0d, empty %0d, out of range %0d, full %0d",
                 sb.status_tally[pls_pkg::STATUS_OK], sb.status_tally[pls_pkg::STATUS_EMPTY],
                 sb.status_tally[pls_pkg::STATUS_RANGE],
                 sb.status_tally[pls_pkg::STATUS_FULL]);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     sb.mismatches, sb.outstanding());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
